FILE: hw/rtl/dfa_pkg.sv
`timescale 1ns / 1ps

package dfa_pkg;

  // Automaton dimensions
  localparam int NumStates  = 64;
  localparam int NumSymbols = 64;
  localparam int StateW     = $clog2(NumStates);
  localparam int SymW       = $clog2(NumSymbols);
  localparam int AddrW      = StateW + SymW;
  localparam int SymCntW    = SymW + 1;

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = SymCntW;
  localparam logic [CfgIdxW-1:0] CfgStartState  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSymbolCount = 1'd1;
  localparam logic [StateW-1:0]  StartStateRst  = '0;
  localparam logic [SymCntW-1:0] SymbolCountRst = SymCntW'(NumSymbols);

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdMark  = 2'd1,
    CmdSym   = 2'd2,
    CmdEnd   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    VerdictAccept  = 2'd0,
    VerdictReject  = 2'd1,
    VerdictIllegal = 2'd2
  } verdict_e;

  typedef struct packed {
    logic              vld;
    logic [StateW-1:0] nxt;
  } entry_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [StateW-1:0] st;
    logic [SymW-1:0]   sym;
    logic [StateW-1:0] nxt;
  } item_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    entry_t           data;
  } wr_req_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [StateW-1:0] last;
  } result_t;

endpackage

FILE: hw/rtl/dfa_tbl_mem.sv
`timescale 1ns / 1ps

module dfa_tbl_mem (
  input  logic                     clk_i,
  input  dfa_pkg::wr_req_t         wr_i,
  input  logic                     rd_en_i,
  input  logic [dfa_pkg::AddrW-1:0] rd_addr_i,
  output dfa_pkg::entry_t          rd_data_o
);
  import dfa_pkg::*;

  localparam int Depth = 1 << AddrW;

  entry_t mem_q [Depth];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Bypass a same-cycle write so the reader sees the newest entry
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_q <= wr_i.data;
      end else begin
        rd_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: hw/rtl/dfa_eval.sv
`timescale 1ns / 1ps

module dfa_eval (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        rd_en_i,
  input  logic                        clr_i,
  input  logic [dfa_pkg::StateW-1:0]  clr_addr_i,
  input  dfa_pkg::item_t              item_i,
  input  dfa_pkg::entry_t             entry_i,
  input  logic [dfa_pkg::StateW-1:0]  start_state_i,
  input  logic [dfa_pkg::SymCntW-1:0] symbol_count_i,
  output logic [dfa_pkg::StateW-1:0]  lookup_state_o,
  output dfa_pkg::wr_req_t            wr_o,
  output dfa_pkg::result_t            res_o
);
  import dfa_pkg::*;

  logic [StateW-1:0] cur_q, cur_d;
  logic              fresh_q, fresh_d;
  logic              ill_q, ill_d;
  logic [StateW-1:0] base;

  logic              acc_mem_q [NumStates];
  logic              acc_rd_q;
  logic              acc_we;
  logic [StateW-1:0] acc_waddr;
  logic              acc_wdata;

  assign base = fresh_q ? start_state_i : cur_q;

  // State seen by the next item once the current one leaves evaluation
  assign lookup_state_o = fresh_d ? start_state_i : cur_d;

  always_comb begin
    cur_d         = cur_q;
    fresh_d       = fresh_q;
    ill_d         = ill_q;
    wr_o.en       = 1'b0;
    wr_o.addr     = {item_i.st, item_i.sym};
    wr_o.data.vld = 1'b1;
    wr_o.data.nxt = item_i.nxt;
    if (fire_i) begin
      unique case (item_i.cmd)
        CmdWrite: begin
          // keep the first written entry
          wr_o.en = !entry_i.vld;
        end
        CmdMark: ;
        CmdSym: begin
          cur_d   = base;
          fresh_d = 1'b0;
          if (!ill_q) begin
            if ({1'b0, item_i.sym} >= symbol_count_i || !entry_i.vld) begin
              ill_d = 1'b1;
            end else begin
              cur_d = entry_i.nxt;
            end
          end
        end
        CmdEnd: begin
          cur_d   = start_state_i;
          fresh_d = 1'b1;
          ill_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Clear the accepting flags during the sweep, set one on a mark item
  assign acc_we    = clr_i || (fire_i && (item_i.cmd == CmdMark));
  assign acc_waddr = clr_i ? clr_addr_i : item_i.st;
  assign acc_wdata = !clr_i;

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem_q[acc_waddr] <= acc_wdata;
    end
  end

  // Fetch the flag of the state an end item will judge; forward a same-cycle mark
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (acc_we && (acc_waddr == lookup_state_o)) begin
        acc_rd_q <= acc_wdata;
      end else begin
        acc_rd_q <= acc_mem_q[lookup_state_o];
      end
    end
  end

  always_comb begin
    res_o.last = base;
    if (ill_q) begin
      res_o.verdict = VerdictIllegal;
    end else if (acc_rd_q) begin
      res_o.verdict = VerdictAccept;
    end else begin
      res_o.verdict = VerdictReject;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      fresh_q <= 1'b1;
      ill_q   <= 1'b0;
    end else begin
      cur_q   <= cur_d;
      fresh_q <= fresh_d;
      ill_q   <= ill_d;
    end
  end

endmodule

FILE: hw/rtl/table_driven_dfa_acceptor.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i                  cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_stall_o   in_cmd_i, in_state_index_i,
//                                                in_symbol_i, in_next_state_i
// out       out        out_valid_o / out_stall_i out_verdict_o, out_last_state_o
//
// After reset a clearing pass writes all 4096 transition entries, one per cycle, and
// clears the accepting flags on the way; intake stalls until the pass is done.
// Configuration writes are taken during the pass. Write, mark and end items transfer
// one per cycle unless intake is held; an end item's result goes from the evaluation
// register into the output register. A symbol behind a symbol waits for its state;
// a held result stalls intake only once the next end item reaches evaluation.

module table_driven_dfa_acceptor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dfa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   in_cmd_i,
  input  logic [dfa_pkg::StateW-1:0]   in_state_index_i,
  input  logic [dfa_pkg::SymW-1:0]     in_symbol_i,
  input  logic [dfa_pkg::StateW-1:0]   in_next_state_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   out_verdict_o,
  output logic [dfa_pkg::StateW-1:0]   out_last_state_o
);
  import dfa_pkg::*;

  typedef enum logic [1:0] {
    ClrSweep = 2'b01,
    ClrRun   = 2'b10
  } clr_state_e;

  clr_state_e        clr_state_q, clr_state_d;
  logic [AddrW-1:0]  clr_cnt_q, clr_cnt_d;

  logic [StateW-1:0]  start_q;
  logic [SymCntW-1:0] symcnt_q;

  item_t             s1_q;
  logic              s1_valid_q;
  logic              s1_fire;
  logic              in_accept;
  item_t             in_item;

  logic              out_valid_q;
  result_t           out_q;

  logic [StateW-1:0] lookup_state;
  logic [AddrW-1:0]  rd_addr;
  entry_t            rd_entry;
  wr_req_t           eval_wr;
  wr_req_t           mem_wr;
  result_t           eval_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= StartStateRst;
      symcnt_q <= SymbolCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartState:  start_q  <= cfg_data_i[StateW-1:0];
        CfgSymbolCount: symcnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clearing pass over the transition memory
  always_comb begin
    clr_state_d = clr_state_q;
    clr_cnt_d   = clr_cnt_q;
    unique case (clr_state_q)
      ClrSweep: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          clr_state_d = ClrRun;
        end
      end
      ClrRun: ;
      default: clr_state_d = ClrSweep;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_state_q <= ClrSweep;
      clr_cnt_q   <= '0;
    end else begin
      clr_state_q <= clr_state_d;
      clr_cnt_q   <= clr_cnt_d;
    end
  end

  assign in_item.cmd = cmd_e'(in_cmd_i);
  assign in_item.st  = in_state_index_i;
  assign in_item.sym = in_symbol_i;
  assign in_item.nxt = in_next_state_i;

  // Evaluation stage advances unless an end item finds the output register blocked
  assign s1_fire = s1_valid_q &&
                   ((s1_q.cmd != CmdEnd) || !out_valid_q || !out_stall_i);

  // Hold intake while clearing, while the evaluation stage is stuck, and while
  // a symbol lookup is in flight and another symbol is offered
  assign in_stall_o = (clr_state_q != ClrRun) ||
                      (s1_valid_q && !s1_fire) ||
                      (s1_valid_q && (s1_q.cmd == CmdSym) && (in_item.cmd == CmdSym));
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_item;
    end
  end

  // Symbols index by the live state, transition writes by the given source state
  assign rd_addr = (in_item.cmd == CmdSym) ? {lookup_state, in_symbol_i} :
                                             {in_state_index_i, in_symbol_i};

  always_comb begin
    if (clr_state_q == ClrSweep) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = clr_cnt_q;
      mem_wr.data = '0;
    end else begin
      mem_wr = eval_wr;
    end
  end

  dfa_tbl_mem u_tbl_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (in_accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  dfa_eval u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (s1_fire),
    .rd_en_i        (in_accept),
    .clr_i          (clr_state_q == ClrSweep),
    .clr_addr_i     (clr_cnt_q[StateW-1:0]),
    .item_i         (s1_q),
    .entry_i        (rd_entry),
    .start_state_i  (start_q),
    .symbol_count_i (symcnt_q),
    .lookup_state_o (lookup_state),
    .wr_o           (eval_wr),
    .res_o          (eval_res)
  );

  // Output register: load on an end item, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && (s1_q.cmd == CmdEnd)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && (s1_q.cmd == CmdEnd)) begin
      out_q <= eval_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_verdict_o    = out_q.verdict;
  assign out_last_state_o = out_q.last;

  // A new result only follows an end item leaving evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && (s1_q.cmd == CmdEnd)))
    else $error("result without end item");

  // A stuck evaluation stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_q)))
    else $error("evaluation item lost");

  // Clearing runs once after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_state_q == ClrRun) |=> (clr_state_q == ClrRun))
    else $error("clearing pass restarted");

  // No transition write from evaluation while the sweep owns the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_state_q == ClrSweep) |-> !s1_valid_q)
    else $error("item in flight during clearing");

endmodule

FILE: sim/table_driven_dfa_acceptor_tb.sv
`timescale 1ns / 1ps

module table_driven_dfa_acceptor_tb;
  import dfa_pkg::*;

  // Longest quiet stretch of a correct run is the table clearing pass after
  // reset; allow several times its length before declaring a hang.
  localparam int QuietLimit = 20000;

  // Shadow of the automaton: table, accepting flags, string state and the
  // verdicts still owed by the block, oldest first.
  class dfa_shadow;
    bit                tbl_vld [4096];
    logic [StateW-1:0] tbl_nxt [4096];
    bit                accepting [NumStates];
    logic [StateW-1:0] cur = '0;
    bit                fresh = 1'b1;
    bit                illegal = 1'b0;
    logic [StateW-1:0] start = StartStateRst;
    logic [SymCntW-1:0] sym_limit = SymbolCountRst;
    result_t           verdict_q [$];
    int                items = 0;
    int                reg_writes = 0;
    int                errors = 0;
    int                verdict_seen [3];

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      reg_writes++;
      if (idx == CfgStartState) start = data[StateW-1:0];
      else sym_limit = data;
    endfunction

    // State the next symbol steps from.
    function logic [StateW-1:0] live_state();
      return fresh ? start : cur;
    endfunction

    function bit can_step(logic [SymW-1:0] sym);
      return ({1'b0, sym} < sym_limit) && tbl_vld[{live_state(), sym}];
    endfunction

    function void apply_item(cmd_e cmd, logic [StateW-1:0] st, logic [SymW-1:0] sym,
                             logic [StateW-1:0] nxt);
      result_t want;
      items++;
      case (cmd)
        CmdWrite: begin
          // keep the first entry written for a (state, symbol) pair
          if (!tbl_vld[{st, sym}]) begin
            tbl_vld[{st, sym}] = 1'b1;
            tbl_nxt[{st, sym}] = nxt;
          end
        end
        CmdMark: accepting[st] = 1'b1;
        CmdSym: begin
          cur = live_state();
          fresh = 1'b0;
          if (!illegal) begin
            if (!can_step(sym)) illegal = 1'b1;
            else cur = tbl_nxt[{cur, sym}];
          end
        end
        default: begin
          cur = live_state();
          want.verdict = illegal ? VerdictIllegal :
                         accepting[cur] ? VerdictAccept : VerdictReject;
          want.last = cur;
          verdict_q.push_back(want);
          verdict_seen[int'(want.verdict)]++;
          // rearm for the next string
          cur = start;
          fresh = 1'b1;
          illegal = 1'b0;
        end
      endcase
    endfunction

    function void match_verdict(logic [1:0] verdict, logic [StateW-1:0] last);
      result_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: verdict %0d last_state %0d",
                   $time, verdict, last);
        return;
      end
      want = verdict_q.pop_front();
      if (verdict !== want.verdict || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] mismatch: verdict exp %0d got %0d, last_state exp %0d got %0d",
                   $time, want.verdict, verdict, want.last, last);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          in_cmd_i = '0;
  logic [StateW-1:0]   in_state_index_i = '0;
  logic [SymW-1:0]     in_symbol_i = '0;
  logic [StateW-1:0]   in_next_state_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          out_verdict_o;
  logic [StateW-1:0]   out_last_state_o;

  dfa_shadow         shadow = new;
  bit                calm = 1'b0;   // no idling on either side once set
  int                gap_pct = 30;  // chance of a sender gap after a transfer
  int                quiet_cycles = 0;
  logic [StateW-1:0] pool [8];      // working set of states for one phase

  table_driven_dfa_acceptor i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_cmd_i         (in_cmd_i),
    .in_state_index_i (in_state_index_i),
    .in_symbol_i      (in_symbol_i),
    .in_next_state_i  (in_next_state_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_verdict_o    (out_verdict_o),
    .out_last_state_o (out_last_state_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Drive one item and hold it until the block takes the transfer, then
  // maybe drop valid for a short burst.
  task automatic send_item(input cmd_e cmd, input logic [StateW-1:0] st,
                           input logic [SymW-1:0] sym, input logic [StateW-1:0] nxt);
    int gap;
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    in_cmd_i         <= cmd;
    in_state_index_i <= st;
    in_symbol_i      <= sym;
    in_next_state_i  <= nxt;
    do @(posedge clk_i); while (in_stall_o);
    shadow.apply_item(cmd, st, sym, nxt);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Park the sender until every owed verdict has come out, then let the
  // pipeline drain items that produce no result.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    shadow.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed strings over the phase's working set: symbols that
  // follow a defined transition, with random writes, marks and noise mixed in.
  task automatic random_item();
    int                roll;
    logic [StateW-1:0] st;
    logic [SymW-1:0]   sym;
    logic [StateW-1:0] nxt;
    roll = $urandom_range(0, 99);
    st   = ($urandom_range(0, 9) == 0) ? StateW'($urandom) : pool[$urandom_range(0, 7)];
    nxt  = ($urandom_range(0, 9) == 0) ? StateW'($urandom) : pool[$urandom_range(0, 7)];
    sym  = ($urandom_range(0, 9) == 0) ? SymW'($urandom) : SymW'($urandom_range(0, 7));
    if (roll < 20) begin
      send_item(CmdWrite, st, sym, nxt);
    end else if (roll < 25) begin
      send_item(CmdMark, st, sym, nxt);
    end else if (roll < 85) begin
      if ($urandom_range(0, 9) != 0)
        for (int k = 0; k < 16 && !shadow.can_step(sym); k++)
          sym = SymW'($urandom_range(0, 7));
      send_item(CmdSym, st, sym, nxt);
    end else begin
      send_item(CmdEnd, st, sym, nxt);
    end
  endtask

  // Receiver: random stall bursts between ready stretches.
  initial begin
    forever begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      if (!calm) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // Check every result transfer against the oldest owed verdict.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      shadow.match_verdict(out_verdict_o, out_last_state_o);
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("[%0t] no transfer for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [StateW-1:0]  s_cfg;
    logic [SymCntW-1:0] c_cfg;
    int                 n_items;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers are taken during the clearing pass; input waits for it.
    set_reg(CfgStartState, CfgDataW'(0));
    set_reg(CfgSymbolCount, CfgDataW'(64));

    // Extremes of every field, a duplicate write, empty string, accepted,
    // rejected and illegal strings, symbols ignored after an illegal one.
    send_item(CmdWrite, 6'd0, 6'd0, 6'd63);
    send_item(CmdWrite, 6'd63, 6'd63, 6'd0);
    send_item(CmdWrite, 6'd0, 6'd0, 6'd5);     // duplicate pair, first entry stays
    send_item(CmdMark, 6'd63, 6'd0, 6'd0);
    send_item(CmdEnd, 6'd0, 6'd0, 6'd0);       // empty string judges the start state
    send_item(CmdSym, 6'd0, 6'd0, 6'd0);
    send_item(CmdEnd, 6'd0, 6'd0, 6'd0);
    send_item(CmdSym, 6'd0, 6'd0, 6'd0);
    send_item(CmdSym, 6'd0, 6'd63, 6'd0);
    send_item(CmdEnd, 6'd63, 6'd63, 6'd63);
    send_item(CmdSym, 6'd0, 6'd1, 6'd0);       // no transition defined
    send_item(CmdSym, 6'd0, 6'd0, 6'd0);       // ignored once illegal
    send_item(CmdEnd, 6'd0, 6'd0, 6'd0);
    send_item(CmdWrite, 6'd63, 6'd42, 6'd21);
    send_item(CmdMark, 6'd21, 6'd42, 6'd42);
    send_item(CmdSym, 6'd21, 6'd0, 6'd42);
    send_item(CmdSym, 6'd42, 6'd42, 6'd21);
    send_item(CmdEnd, 6'd42, 6'd21, 6'd42);

    // Symbol at the alphabet size is illegal even with an entry behind it.
    settle();
    set_reg(CfgSymbolCount, CfgDataW'(42));
    send_item(CmdSym, 6'd0, 6'd0, 6'd0);
    send_item(CmdSym, 6'd0, 6'd42, 6'd0);
    send_item(CmdEnd, 6'd0, 6'd0, 6'd0);

    // Accepting start state, then a step out of it.
    settle();
    set_reg(CfgStartState, CfgDataW'(63));
    set_reg(CfgSymbolCount, CfgDataW'(64));
    send_item(CmdEnd, 6'd0, 6'd0, 6'd0);
    send_item(CmdSym, 6'd0, 6'd63, 6'd0);
    send_item(CmdEnd, 6'd0, 6'd0, 6'd0);

    // Random phases, each with its own register setting and working set.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin s_cfg = 6'd0;  c_cfg = 7'd64; n_items = 300; gap_pct = 25; end
        1: begin s_cfg = 6'd63; c_cfg = 7'd0;  n_items = 80;  gap_pct = 50; end
        2: begin
          s_cfg = StateW'($urandom); c_cfg = 7'd1; n_items = 120; gap_pct = 0;
        end
        3: begin
          s_cfg = StateW'($urandom); c_cfg = SymCntW'($urandom_range(2, 63));
          n_items = 300; gap_pct = 30;
        end
        4: begin
          s_cfg = StateW'($urandom); c_cfg = 7'd64; n_items = 300; gap_pct = 10;
        end
        default: begin s_cfg = 6'd42; c_cfg = 7'd8; n_items = 250; gap_pct = 0; end
      endcase
      settle();
      set_reg(CfgStartState, CfgDataW'(s_cfg));
      set_reg(CfgSymbolCount, CfgDataW'(c_cfg));
      pool[0] = s_cfg;
      for (int k = 1; k < 8; k++) pool[k] = StateW'($urandom);
      if (ph == 5) calm = 1'b1;
      repeat (n_items) random_item();
    end

    // Drain: wait for every owed verdict, then let stragglers drain.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Covered %0d items across %0d register writes; verdicts %0d accepted, %0d rejected, %0d illegal",
             shadow.items, shadow.reg_writes, shadow.verdict_seen[0],
             shadow.verdict_seen[1], shadow.verdict_seen[2]);
    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", shadow.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
